FILE: rtl/core/quadratic_bezier_flattener_macros.svh
// assertion macros for the quadratic bezier flattener
`ifndef QUADRATIC_BEZIER_FLATTENER_MACROS_SVH
`define QUADRATIC_BEZIER_FLATTENER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define QBF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbf: assertion failed");
// next-cycle implication
`define QBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbf: assertion failed");
`else
`define QBF_ASSERT(lbl, ante, cons)
`define QBF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/qbf_pkg.sv
// constants and helpers shared by the quadratic bezier flattener
`timescale 1ns / 1ps
package qbf_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_STEPS_DEF   = 64;

  // step count register
  localparam int          STEP_W       = 3;
  localparam int          STEP_CAP     = 6;
  localparam logic [2:0]  STEP_RESET   = 3'd6;
  // shift amount 2*s for s up to STEP_CAP
  localparam int          SHIFT_W      = 4;

  localparam int NUM_AXES = 2;
  localparam int AXIS_X   = 0;
  localparam int AXIS_Y   = 1;

  // largest s with 2^s <= max_steps, capped
  function automatic int max_log2(input int max_steps);
    int s;
    s = 0;
    while (s < STEP_CAP && (1 << (s + 1)) <= max_steps) begin
      s = s + 1;
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/quadratic_bezier_flattener.sv
// quadratic bezier flattener: curve in, run of line segments out
//
// Input channel (in_valid / in_stall): one request carries the control points
// P0, P1, P2. Result channel (out_valid / out_stall): 2^s segments per curve,
// each the exact rounded curve points at t=(k-1)/N and t=k/N; the final one
// has last_segment set. Config channel (cfg_valid / cfg_ready): writes s,
// taken at any time but meant to change only while the block is idle; s is
// limited to log2(MAX_STEPS) and to 6.
// Throughput: one segment per cycle while the output is not stalled; the next
// curve is taken on the cycle its predecessor issues its last segment, so runs
// follow one another with no gap. The segment counter sets the rate, issuing
// one curve point a cycle while the output is not held. The first segment
// passes the segment counter, weight stage, multiply stage, sum stage and
// output register in that order.
// Reset (rst_n low at a clock edge) empties the pipeline and sets s to 6.
// While a segment waits in the output register under out_stall the whole
// pipeline and the counter hold in place, empty slots ahead of it included.
`timescale 1ns / 1ps
`include "quadratic_bezier_flattener_macros.svh"
module quadratic_bezier_flattener #(
  parameter int COORD_WIDTH = qbf_pkg::COORD_WIDTH_DEF,
  parameter int MAX_STEPS   = qbf_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qbf_pkg::STEP_W-1:0]    cfg_step_count_log2,
  // curve requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_p0_x,
  input  logic signed [COORD_WIDTH-1:0] in_p0_y,
  input  logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [COORD_WIDTH-1:0] in_p2_y,
  // segments
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_seg_start_x,
  output logic signed [COORD_WIDTH-1:0] out_seg_start_y,
  output logic signed [COORD_WIDTH-1:0] out_seg_end_x,
  output logic signed [COORD_WIDTH-1:0] out_seg_end_y,
  output logic                          out_last_segment
);
  import qbf_pkg::*;

  localparam int LIM    = max_log2(MAX_STEPS);
  localparam int CNT_W  = LIM + 1;
  localparam int WGT_W  = 2 * LIM + 1;
  localparam int PROD_W = COORD_WIDTH + WGT_W;
  localparam logic [COORD_WIDTH-1:0] HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [STEP_W-1:0]      LIM_S = STEP_W'(LIM);

  // configuration register
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_eff;

  // curve sequencer
  logic                   cur_valid_r;
  logic [STEP_W-1:0]      s_r;
  logic [CNT_W-1:0]       k_r;
  logic [CNT_W-1:0]       n_cur;
  logic [CNT_W-1:0]       j_cur;
  logic [COORD_WIDTH-1:0] cur_a_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] cur_b_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] cur_c_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] in_a [NUM_AXES];
  logic [COORD_WIDTH-1:0] in_b [NUM_AXES];
  logic [COORD_WIDTH-1:0] in_c [NUM_AXES];
  logic                   issue;
  logic                   issue_last;
  logic                   in_take;
  logic                   adv;
  logic [WGT_W-1:0]       w0_nxt;
  logic [WGT_W-1:0]       w1_nxt;
  logic [WGT_W-1:0]       w2_nxt;

  // stage 1: weights
  logic                   s1_valid_r;
  logic                   s1_first_r;
  logic                   s1_last_r;
  logic [STEP_W-1:0]      s1_s_r;
  logic [WGT_W-1:0]       s1_w0_r;
  logic [WGT_W-1:0]       s1_w1_r;
  logic [WGT_W-1:0]       s1_w2_r;
  logic [COORD_WIDTH-1:0] s1_a_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] s1_b_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] s1_c_r [NUM_AXES];

  // stage 2: products
  logic                   s2_valid_r;
  logic                   s2_first_r;
  logic                   s2_last_r;
  logic [STEP_W-1:0]      s2_s_r;
  logic [PROD_W-1:0]      s2_pa_r [NUM_AXES];
  logic [PROD_W-1:0]      s2_pb_r [NUM_AXES];
  logic [PROD_W-1:0]      s2_pc_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] s2_p0_r [NUM_AXES];
  logic [PROD_W-1:0]      s2_rnd;

  // stage 3: rounded sums
  logic                   s3_valid_r;
  logic                   s3_first_r;
  logic                   s3_last_r;
  logic [STEP_W-1:0]      s3_s_r;
  logic [PROD_W-1:0]      s3_sum_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] s3_p0_r  [NUM_AXES];
  logic [COORD_WIDTH-1:0] pt       [NUM_AXES];
  logic [PROD_W-1:0]      shifted  [NUM_AXES];

  // output register
  logic                   out_valid_r;
  logic                   out_last_r;
  logic [COORD_WIDTH-1:0] out_start_r [NUM_AXES];
  logic [COORD_WIDTH-1:0] out_end_r   [NUM_AXES];
  logic [COORD_WIDTH-1:0] prev_r      [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign step_eff  = (step_r > LIM_S) ? LIM_S : step_r;

  // whole pipeline moves together unless the output register is held
  assign adv        = !out_valid_r || !out_stall;
  assign issue      = cur_valid_r && adv;
  assign n_cur      = CNT_W'(1) << s_r;
  assign j_cur      = n_cur - k_r;
  assign issue_last = issue && (k_r == n_cur);
  assign in_stall   = cur_valid_r && !issue_last;
  assign in_take    = in_valid && !in_stall;

  assign w0_nxt = WGT_W'(j_cur) * WGT_W'(j_cur);
  assign w1_nxt = (WGT_W'(k_r) * WGT_W'(j_cur)) << 1;
  assign w2_nxt = WGT_W'(k_r) * WGT_W'(k_r);

  // coordinates offset to unsigned; weights sum to n^2 so the offset drops out
  always_comb begin
    in_a[AXIS_X] = in_p0_x ^ HALF;
    in_a[AXIS_Y] = in_p0_y ^ HALF;
    in_b[AXIS_X] = in_p1_x ^ HALF;
    in_b[AXIS_Y] = in_p1_y ^ HALF;
    in_c[AXIS_X] = in_p2_x ^ HALF;
    in_c[AXIS_Y] = in_p2_y ^ HALF;
  end

  assign s2_rnd = (s2_s_r == '0) ? '0 :
                  (PROD_W'(1) << ({s2_s_r, 1'b0} - SHIFT_W'(1)));

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      shifted[ax] = s3_sum_r[ax] >> {s3_s_r, 1'b0};
      pt[ax]      = shifted[ax][COORD_WIDTH-1:0] ^ HALF;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      cur_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_step_count_log2;
      end
      if (in_take) begin
        cur_valid_r <= 1'b1;
      end else if (issue_last) begin
        cur_valid_r <= 1'b0;
      end
      if (adv) begin
        s1_valid_r  <= cur_valid_r;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_r <= step_eff;
      k_r <= CNT_W'(1);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        cur_a_r[ax] <= in_a[ax];
        cur_b_r[ax] <= in_b[ax];
        cur_c_r[ax] <= in_c[ax];
      end
    end else if (issue) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= (k_r == CNT_W'(1));
      s1_last_r  <= (k_r == n_cur);
      s1_s_r     <= s_r;
      s1_w0_r    <= w0_nxt;
      s1_w1_r    <= w1_nxt;
      s1_w2_r    <= w2_nxt;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_s_r     <= s1_s_r;
      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      s3_s_r     <= s2_s_r;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s1_a_r[ax]   <= cur_a_r[ax];
        s1_b_r[ax]   <= cur_b_r[ax];
        s1_c_r[ax]   <= cur_c_r[ax];
        s2_pa_r[ax]  <= PROD_W'(s1_a_r[ax]) * PROD_W'(s1_w0_r);
        s2_pb_r[ax]  <= PROD_W'(s1_b_r[ax]) * PROD_W'(s1_w1_r);
        s2_pc_r[ax]  <= PROD_W'(s1_c_r[ax]) * PROD_W'(s1_w2_r);
        s2_p0_r[ax]  <= s1_a_r[ax];
        s3_sum_r[ax] <= s2_pa_r[ax] + s2_pb_r[ax] + s2_pc_r[ax] + s2_rnd;
        s3_p0_r[ax]  <= s2_p0_r[ax];
      end
      if (s3_valid_r) begin
        out_last_r <= s3_last_r;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          // first segment starts at P0 exactly
          out_start_r[ax] <= s3_first_r ? (s3_p0_r[ax] ^ HALF) : prev_r[ax];
          out_end_r[ax]   <= pt[ax];
          prev_r[ax]      <= pt[ax];
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_last_segment = out_last_r;
  assign out_seg_start_x  = out_start_r[AXIS_X];
  assign out_seg_start_y  = out_start_r[AXIS_Y];
  assign out_seg_end_x    = out_end_r[AXIS_X];
  assign out_seg_end_y    = out_end_r[AXIS_Y];

  // segment counter stays within 1..n while a curve is active
  `QBF_ASSERT(a_k_range, cur_valid_r, (k_r != '0) && (k_r <= n_cur))
  // a held pipeline keeps its points
  `QBF_ASSERT_NEXT(a_s3_hold, s3_valid_r && !adv, s3_valid_r)
  // segments of one curve join end to start
  `QBF_ASSERT_NEXT(a_chain, out_valid && !out_stall && !out_last_segment,
    !out_valid || (out_seg_start_x == $past(out_seg_end_x) &&
                   out_seg_start_y == $past(out_seg_end_y)))

endmodule
